FILE: design/u8dv_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decode and validate package
// Status codes and byte masks shared by the decoder and its checker.
// ----------------------------------------------------------------------------
package u8dv_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEAD  = 2'd1,
    ST_BAD_TRAIL = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned LenWidth = 3;

  localparam logic [7:0] AsciiLimit    = 8'h80;
  localparam logic [7:0] ThreeByteLead = 8'hE0;
  localparam logic [7:0] FourByteLead  = 8'hF0;
  localparam logic [7:0] FirstBadHigh  = 8'hF5;
  localparam logic [7:0] BadLeadC0     = 8'hC0;
  localparam logic [7:0] BadLeadC1     = 8'hC1;
  localparam logic [7:0] TwoByteMask   = 8'h1F;
  localparam logic [7:0] ThreeByteMask = 8'h0F;
  localparam logic [7:0] FourByteMask  = 8'h07;
  localparam logic [7:0] TrailMask     = 8'h3F;
  localparam logic [1:0] TrailTag      = 2'b10;

endpackage

FILE: design/utf8_stream_decode_validate.sv
// A result is loaded into the output register at the clock edge that accepts its byte.
// One byte per cycle except while in_stall; decode state updates per accepted byte.
// A held result stalls input only when the downstream side stalls it as well.
// Reset (synchronous, active high) returns the decoder to idle and empties the output.
// ----------------------------------------------------------------------------
// UTF-8 stream decoder and validator
// Decodes one byte per transaction, emitting code points, lengths and errors.
// ----------------------------------------------------------------------------
module utf8_stream_decode_validate (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_in_range,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] code_point,
  output logic [2:0]  char_length,
  output logic [1:0]  status,
  output logic        range_end
);

  logic [1:0]  trail_left, trail_left_next;
  logic [20:0] partial_value, partial_value_next;
  logic [2:0]  seq_length, seq_length_next;

  logic        accept;
  logic        emit;
  logic [20:0] res_cp;
  logic [2:0]  res_len;
  u8dv_pkg::status_t res_st;
  logic [1:0]  trail_dec;
  logic [20:0] shifted;

  // The output register is free when empty or when its contents leave this cycle.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign trail_dec = trail_left - 2'd1;
  assign shifted   = {partial_value[14:0], data_byte[5:0]};

  always_comb begin
    trail_left_next    = trail_left;
    partial_value_next = partial_value;
    seq_length_next    = seq_length;
    emit    = 1'b0;
    res_cp  = '0;
    res_len = '0;
    res_st  = u8dv_pkg::ST_OK;

    if (trail_left == 2'd0) begin
      if (data_byte == u8dv_pkg::BadLeadC0 || data_byte == u8dv_pkg::BadLeadC1 ||
          data_byte >= u8dv_pkg::FirstBadHigh) begin
        emit   = 1'b1;
        res_st = u8dv_pkg::ST_BAD_LEAD;
      end else if (data_byte < u8dv_pkg::AsciiLimit) begin
        emit    = 1'b1;
        res_cp  = {13'd0, data_byte};
        res_len = 3'd1;
      end else begin
        if (data_byte < u8dv_pkg::ThreeByteLead) begin
          partial_value_next = {13'd0, data_byte & u8dv_pkg::TwoByteMask};
          trail_left_next    = 2'd1;
          seq_length_next    = 3'd2;
        end else if (data_byte < u8dv_pkg::FourByteLead) begin
          partial_value_next = {13'd0, data_byte & u8dv_pkg::ThreeByteMask};
          trail_left_next    = 2'd2;
          seq_length_next    = 3'd3;
        end else begin
          partial_value_next = {13'd0, data_byte & u8dv_pkg::FourByteMask};
          trail_left_next    = 2'd3;
          seq_length_next    = 3'd4;
        end
        if (last_in_range) begin
          emit   = 1'b1;
          res_st = u8dv_pkg::ST_TRUNCATED;
        end
      end
    end else if (data_byte[7:6] != u8dv_pkg::TrailTag) begin
      // The offending byte is consumed here and not retried as a lead byte.
      emit   = 1'b1;
      res_st = u8dv_pkg::ST_BAD_TRAIL;
    end else begin
      partial_value_next = shifted;
      trail_left_next    = trail_dec;
      if (trail_dec == 2'd0) begin
        emit    = 1'b1;
        res_cp  = shifted;
        res_len = seq_length;
      end else if (last_in_range) begin
        emit   = 1'b1;
        res_st = u8dv_pkg::ST_TRUNCATED;
      end
    end

    // Every emitted result leaves the decoder idle.
    if (emit) begin
      trail_left_next    = 2'd0;
      partial_value_next = '0;
      seq_length_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trail_left    <= 2'd0;
      partial_value <= '0;
      seq_length    <= '0;
    end else if (accept) begin
      trail_left    <= trail_left_next;
      partial_value <= partial_value_next;
      seq_length    <= seq_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      code_point  <= res_cp;
      char_length <= res_len;
      status      <= res_st;
      range_end   <= last_in_range;
    end
  end

endmodule

FILE: design/u8dv_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder port checker
// Watches the decoder's ports and flags results that break its contract.
// ----------------------------------------------------------------------------
module u8dv_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  data_byte,
  input logic        last_in_range,
  input logic        out_valid,
  input logic        out_stall,
  input logic [20:0] code_point,
  input logic [2:0]  char_length,
  input logic [1:0]  status,
  input logic        range_end
);

  // A stalled result holds until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_point) &&
      $stable(char_length) && $stable(status) && $stable(range_end))
    else $error("stalled result changed");

  // Input is only held back by a result that is itself held back.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Error results carry neither a code point nor a length.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != u8dv_pkg::ST_OK |-> code_point == '0 && char_length == '0)
    else $error("error result with payload");

  // A good character is one to four bytes long.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == u8dv_pkg::ST_OK |-> char_length >= 3'd1 && char_length <= 3'd4)
    else $error("bad character length");

  // A byte that can be neither a lead nor a trail byte yields an error at once.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && data_byte >= u8dv_pkg::FirstBadHigh |=>
      out_valid && range_end == $past(last_in_range) &&
      (status == u8dv_pkg::ST_BAD_LEAD || status == u8dv_pkg::ST_BAD_TRAIL))
    else $error("invalid byte not reported");

endmodule

bind utf8_stream_decode_validate u8dv_checker u_u8dv_checker (.*);

FILE: sim/utf8_stream_decode_validate_chk.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder checker
// Watches both channels of the decoder, predicts the result of every accepted
// byte and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_stream_decode_validate_chk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          last_in_range,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [u8dv_pkg::CpWidth-1:0]  code_point,
  input  logic [u8dv_pkg::LenWidth-1:0] char_length,
  input  logic [1:0]                    status,
  input  logic                          range_end,
  output int                            fail_count,
  output int                            pending
);

  typedef struct packed {
    logic [u8dv_pkg::CpWidth-1:0]  cp;
    logic [u8dv_pkg::LenWidth-1:0] len;
    u8dv_pkg::status_t             st;
    logic                          rend;
  } char_result_t;

  logic [1:0]                    trail_left = '0;
  logic [u8dv_pkg::CpWidth-1:0]  partial_cp = '0;
  logic [u8dv_pkg::LenWidth-1:0] seq_len    = '0;
  char_result_t                  expected_chars[$];
  int                            fails      = 0;
  int                            waiting    = 0;

  assign fail_count = fails;
  assign pending    = waiting;

  // Advances the decode state by one byte; returns 1 when the byte completes
  // a character or ends a sequence in error.
  function automatic bit decode_byte(input logic [7:0] b, input logic lst,
                                     output char_result_t r);
    r = '{cp: '0, len: '0, st: u8dv_pkg::ST_OK, rend: lst};
    if (trail_left == 2'd0) begin
      if (b == u8dv_pkg::BadLeadC0 || b == u8dv_pkg::BadLeadC1 ||
          b >= u8dv_pkg::FirstBadHigh) begin
        r.st = u8dv_pkg::ST_BAD_LEAD;
        return 1'b1;
      end
      if (b < u8dv_pkg::AsciiLimit) begin
        r.cp  = u8dv_pkg::CpWidth'(b);
        r.len = u8dv_pkg::LenWidth'(1);
        return 1'b1;
      end
      // Stray continuation bytes fall into the two-byte class here.
      if (b < u8dv_pkg::ThreeByteLead) begin
        partial_cp = u8dv_pkg::CpWidth'(b & u8dv_pkg::TwoByteMask);
        trail_left = 2'd1;
        seq_len    = u8dv_pkg::LenWidth'(2);
      end else if (b < u8dv_pkg::FourByteLead) begin
        partial_cp = u8dv_pkg::CpWidth'(b & u8dv_pkg::ThreeByteMask);
        trail_left = 2'd2;
        seq_len    = u8dv_pkg::LenWidth'(3);
      end else begin
        partial_cp = u8dv_pkg::CpWidth'(b & u8dv_pkg::FourByteMask);
        trail_left = 2'd3;
        seq_len    = u8dv_pkg::LenWidth'(4);
      end
      if (lst) begin
        trail_left = '0;
        partial_cp = '0;
        seq_len    = '0;
        r.st       = u8dv_pkg::ST_TRUNCATED;
        return 1'b1;
      end
      return 1'b0;
    end
    if (b[7:6] != u8dv_pkg::TrailTag) begin
      trail_left = '0;
      partial_cp = '0;
      seq_len    = '0;
      r.st       = u8dv_pkg::ST_BAD_TRAIL;
      return 1'b1;
    end
    partial_cp = (partial_cp << 6) | u8dv_pkg::CpWidth'(b & u8dv_pkg::TrailMask);
    trail_left = trail_left - 2'd1;
    if (trail_left == 2'd0) begin
      r.cp       = partial_cp;
      r.len      = seq_len;
      partial_cp = '0;
      seq_len    = '0;
      return 1'b1;
    end
    if (lst) begin
      trail_left = '0;
      partial_cp = '0;
      seq_len    = '0;
      r.st       = u8dv_pkg::ST_TRUNCATED;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    char_result_t got;
    char_result_t want;
    char_result_t pred;
    if (rst) begin
      trail_left = '0;
      partial_cp = '0;
      seq_len    = '0;
      expected_chars.delete();
      waiting = 0;
    end else begin
      // The output is checked before the input is predicted: a result never
      // leaves in the same cycle as the byte that caused it.
      if (out_valid && !out_stall) begin
        got = {code_point, char_length, status, range_end};
        if (expected_chars.size() == 0) begin
          if (fails < 10)
            $display("unexpected result: cp=%h len=%0d st=%0d end=%b",
                     got.cp, got.len, got.st, got.rend);
          fails++;
        end else begin
          want = expected_chars.pop_front();
          if (got.cp !== want.cp || got.len !== want.len || got.st !== want.st ||
              got.rend !== want.rend) begin
            if (fails < 10)
              $display({"mismatch: expected cp=%h len=%0d st=%0d end=%b,",
                        " got cp=%h len=%0d st=%0d end=%b"},
                       want.cp, want.len, want.st, want.rend,
                       got.cp, got.len, got.st, got.rend);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (decode_byte(data_byte, last_in_range, pred))
          expected_chars.push_back(pred);
      end
      waiting = expected_chars.size();
    end
  end

endmodule

FILE: sim/utf8_stream_decode_validate_tb.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Drives directed and random byte streams with random idling on both sides,
// a long output hold-off, and leaves checking to the checker module.
// ----------------------------------------------------------------------------
module utf8_stream_decode_validate_tb;

  logic                          clk           = 1'b0;
  logic                          rst           = 1'b1;
  logic                          in_valid      = 1'b0;
  logic [7:0]                    data_byte     = '0;
  logic                          last_in_range = 1'b0;
  logic                          out_stall     = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  logic [u8dv_pkg::CpWidth-1:0]  code_point;
  logic [u8dv_pkg::LenWidth-1:0] char_length;
  logic [1:0]                    status;
  logic                          range_end;

  logic quiet    = 1'b0;
  logic hold_req = 1'b0;
  int   bytes_sent = 0;
  int   fail_count;
  int   pending;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  utf8_stream_decode_validate uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_in_range (last_in_range),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .code_point    (code_point),
    .char_length   (char_length),
    .status        (status),
    .range_end     (range_end)
  );

  utf8_stream_decode_validate_chk chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_in_range (last_in_range),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .code_point    (code_point),
    .char_length   (char_length),
    .status        (status),
    .range_end     (range_end),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Offers one byte and returns once the transaction has been accepted.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (!quiet && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    last_in_range <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends one character with random content; it may be cut short by an early
  // range end or broken by a byte that is not a trail byte.
  task automatic send_char(input bit truncate, input bit break_trail);
    logic [7:0] lead;
    logic [7:0] b;
    logic       at_end;
    int         n;
    int         cut;
    int         bad;
    n = $urandom_range(1, 4);
    case (n)
      1: lead = 8'($urandom_range(0, 8'h7F));
      2: begin
        lead = 8'($urandom_range(8'h80, 8'hDF));
        if (lead == u8dv_pkg::BadLeadC0 || lead == u8dv_pkg::BadLeadC1) lead = 8'hC2;
      end
      3: lead = 8'($urandom_range(8'hE0, 8'hEF));
      default: lead = 8'($urandom_range(8'hF0, 8'hF4));
    endcase
    at_end = ($urandom_range(0, 7) == 0);
    cut = (truncate && n > 1) ? $urandom_range(0, n - 2) : n;
    bad = (break_trail && n > 1) ? $urandom_range(1, n - 1) : n;
    for (int i = 0; i < n; i++) begin
      b = (i == 0) ? lead : {u8dv_pkg::TrailTag, 6'($urandom)};
      if (i == bad) begin
        b = 8'($urandom);
        if (b[7:6] == u8dv_pkg::TrailTag) b[6] = 1'b1;
      end
      send_byte(b, (i == cut) || (i == bad && at_end) || (i == n - 1 && at_end));
      if (i == cut || i == bad) break;
    end
  endtask

  // Output side: random stalls, a quiet stretch, and one long hold-off that
  // lets the decoder fill up and push back on its input.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 29);
      end
    end
  end

  initial begin
    int pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(u8dv_pkg::BadLeadC0, 1'b0);
    send_byte(u8dv_pkg::BadLeadC1, 1'b1);
    send_byte(u8dv_pkg::FirstBadHigh, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // A continuation byte seen while idle opens a two-byte sequence.
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    // The last trail byte is also the end of the range, so it still completes.
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hE2, 1'b1);
    // A bad trail byte is consumed and not taken again as a lead byte.
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hC3, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b1);

    while (bytes_sent < 1224) begin
      if (bytes_sent >= 300 && !hold_req) hold_req <= 1'b1;
      quiet <= (bytes_sent >= 600 && bytes_sent < 800);
      pick = $urandom_range(0, 99);
      if (pick < 70) send_char(1'b0, 1'b0);
      else if (pick < 80) send_char(1'b1, 1'b0);
      else if (pick < 88) send_char(1'b0, 1'b1);
      else send_byte(8'($urandom), $urandom_range(0, 3) == 0);
    end
    in_valid <= 1'b0;

    // Waiting on the clock first lets the checker record the final transaction.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** utf8_stream_decode_validate: PASSED **");
    end else begin
      $display("** utf8_stream_decode_validate: FAILED **");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("** utf8_stream_decode_validate: FAILED **");
    $finish;
  end

endmodule
